FILE: sv/afu_pkg.sv
// ----------------------------------------------------------------------------
// afu_pkg
// shared types and constants of the alu flag update unit
// ----------------------------------------------------------------------------
`default_nettype none

package afu_pkg;

	// flag positions in the flag byte: S Z F5 H F3 PV N C
	localparam int unsigned BitC  = 0;
	localparam int unsigned BitN  = 1;
	localparam int unsigned BitPv = 2;
	localparam int unsigned BitF3 = 3;
	localparam int unsigned BitH  = 4;
	localparam int unsigned BitF5 = 5;
	localparam int unsigned BitZ  = 6;
	localparam int unsigned BitS  = 7;

	localparam int unsigned ValueW = 16;
	localparam int unsigned FlagW  = 8;

	// masks for the half-carry compare
	localparam logic [ValueW-1:0] HalfMaskWide   = 16'h0FFF;
	localparam logic [ValueW-1:0] HalfMaskNarrow = 16'h000F;

	typedef logic [ValueW-1:0] value_t;
	typedef logic [FlagW-1:0]  flags_t;

	// operation kind bits, is_subtraction in the lowest bit
	typedef struct packed {
		logic is_wide;
		logic use_parity;
		logic is_subtraction;
	} mode_t;

endpackage : afu_pkg

`default_nettype wire

FILE: sv/afu_flag_gen.sv
// ----------------------------------------------------------------------------
// afu_flag_gen
// fresh flag byte from the old and new values of one operation
// ----------------------------------------------------------------------------
`default_nettype none

module afu_flag_gen (
	input  afu_pkg::value_t old_value,
	input  afu_pkg::value_t new_value,
	input  afu_pkg::mode_t  mode,
	output afu_pkg::flags_t fresh
);

	logic [7:0]       res_byte;
	logic             top_new;
	logic             top_old;
	afu_pkg::value_t  hmask;
	afu_pkg::value_t  new_h;
	afu_pkg::value_t  old_h;
	logic             h_flag;
	logic             c_flag;
	logic             pv_flag;

	always_comb begin
		res_byte = mode.is_wide ? new_value[15:8] : new_value[7:0];
		top_new  = mode.is_wide ? new_value[15] : new_value[7];
		top_old  = mode.is_wide ? old_value[15] : old_value[7];
		hmask    = mode.is_wide ? afu_pkg::HalfMaskWide : afu_pkg::HalfMaskNarrow;
		new_h    = new_value & hmask;
		old_h    = old_value & hmask;

		// subtract sets on borrow (new above old), add on carry (new below old)
		h_flag = mode.is_subtraction ? (new_h > old_h) : (new_h < old_h);
		c_flag = mode.is_subtraction ? (new_value > old_value) : (new_value < old_value);

		// with use_parity: even parity over the whole 16-bit value, also in byte mode; else top bit of new xor old
		pv_flag = mode.use_parity ? ~(^new_value) : (top_new ^ top_old);

		fresh                    = '0;
		fresh[afu_pkg::BitS]     = top_new;
		fresh[afu_pkg::BitZ]     = (new_value == '0);
		fresh[afu_pkg::BitF5]    = res_byte[5];
		fresh[afu_pkg::BitH]     = h_flag;
		fresh[afu_pkg::BitF3]    = res_byte[3];
		fresh[afu_pkg::BitPv]    = pv_flag;
		fresh[afu_pkg::BitN]     = mode.is_subtraction;
		fresh[afu_pkg::BitC]     = c_flag;
	end

endmodule : afu_flag_gen

`default_nettype wire

FILE: sv/alu_flag_update_unit.sv
// ----------------------------------------------------------------------------
// alu_flag_update_unit
// flag register update for an 8/16-bit alu, one operation per word
// ----------------------------------------------------------------------------
// Each input word carries an operation's old and new values, its kind bits
// and a keep mask. The unit builds S Z F5 H F3 PV N C from them and merges
// them into the stored flag register: bits set in keep_mask hold their stored
// value, the rest take the fresh value. The updated register goes out as one
// output word per input word, in order. A word is registered at the input,
// the flags are formed in one pass of combinational logic and land in the
// flag register and the output register together, so one word is taken
// every cycle while the output is not held back. The input register keeps
// taking words while a result waits at the output, until both stages are
// full.
// ----------------------------------------------------------------------------
`default_nettype none

module alu_flag_update_unit (
	input  wire        clk,
	input  wire        arst_n,
	// input stream
	input  wire        s_tvalid,
	output logic       s_tready,
	input  wire [39:0] s_tdata,   // old_value[15:0], new_value[31:16], keep_mask[39:32]
	input  wire [2:0]  s_tuser,   // is_subtraction[0], use_parity[1], is_wide[2]
	// output stream
	output logic       m_tvalid,
	input  wire        m_tready,
	output logic [7:0] m_tdata    // flags[7:0]: S Z F5 H F3 PV N C
);

	// input stage
	logic             valid_s1;
	afu_pkg::value_t  old_s1;
	afu_pkg::value_t  new_s1;
	afu_pkg::flags_t  keep_s1;
	afu_pkg::mode_t   mode_s1;

	// architectural flag register and output word
	afu_pkg::flags_t  flags_q;
	afu_pkg::flags_t  out_q;
	logic             out_valid_q;

	afu_pkg::flags_t  fresh;
	afu_pkg::flags_t  merged;
	logic             advance;

	// stage 1 moves into the output register when that is free or being drained
	assign advance  = valid_s1 && (!out_valid_q || m_tready);
	assign s_tready = !valid_s1 || advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_tready) begin
			valid_s1 <= s_tvalid;
		end
	end

	// payload needs no reset
	always_ff @(posedge clk) begin
		if (s_tvalid && s_tready) begin
			old_s1  <= s_tdata[15:0];
			new_s1  <= s_tdata[31:16];
			keep_s1 <= s_tdata[39:32];
			mode_s1 <= s_tuser;
		end
	end

	afu_flag_gen u_flag_gen (
		.old_value (old_s1),
		.new_value (new_s1),
		.mode      (mode_s1),
		.fresh     (fresh)
	);

	// kept bits come from the stored register, the rest are fresh
	assign merged = (flags_q & keep_s1) | (fresh & ~keep_s1);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			flags_q     <= '0;
			out_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (advance) begin
				flags_q     <= merged;
				out_q       <= merged;
				out_valid_q <= 1'b1;
			end else if (m_tready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = out_q;

	// output word always mirrors the flag register it was taken from
	assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> (m_tdata == flags_q))
		else $error("output word differs from flag register");

	// a full keep mask leaves the register untouched
	assert property (@(posedge clk) disable iff (!arst_n)
		(advance && (keep_s1 == '1)) |=> (flags_q == $past(flags_q)))
		else $error("full keep mask changed flags");

	// an updated N flag follows the subtract bit
	assert property (@(posedge clk) disable iff (!arst_n)
		(advance && !keep_s1[afu_pkg::BitN])
		|=> (flags_q[afu_pkg::BitN] == $past(mode_s1.is_subtraction)))
		else $error("N flag not set from subtract bit");

	// the input stalls only when both stages are full and the output is held
	assert property (@(posedge clk) disable iff (!arst_n)
		!s_tready |-> (valid_s1 && m_tvalid && !m_tready))
		else $error("input stalled without back-pressure");

endmodule : alu_flag_update_unit

`default_nettype wire
